// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/knn_pkg.sv -----
package knn_pkg;
  localparam int MAX_DIM     = 1024;
  localparam int MAX_K       = 64;
  localparam int MAX_BASE    = 1048576;
  localparam int SAMPLE_BITS = 16;
  localparam int DIM_W  = $clog2(MAX_DIM);
  localparam int K_W    = $clog2(MAX_K);
  localparam int BASE_W = $clog2(MAX_BASE) + 1;
  localparam int ID_W   = 20;
  localparam int DIST_W = 44;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_QUERY = 2'd0,
    KIND_BASE  = 2'd1,
    KIND_END   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ELEM, ST_ACC, ST_INS, ST_EMIT
  } state_t;

  localparam logic [0:0] REG_TOP = 1'b0;
  localparam logic [0:0] REG_LEN = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input, read query store
    logic elem;     // process element (query write / base square)
    logic acc;      // accumulate square, maybe finish vector
    logic insert;   // insert finished vector into list
    logic emit;     // present entry emit_idx
    logic clear;    // end of set: clear list and counters
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       is_query;
    logic       is_base;
    logic       is_end;
    logic       finish;     // vector finished in acc step
    logic       emit_done;  // all entries emitted
  } dp_stat_t;
endpackage

// ----- rtl/core/knn_ctrl.sv -----
`include "assert_macros.svh"
module knn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output knn_pkg::dp_cmd_t  cmd,
  input  knn_pkg::dp_stat_t stat
);
  import knn_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ELEM;
        end
      end
      ST_ELEM: begin
        priority if (stat.is_query) begin
          cmd.elem  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (stat.is_base) begin
          cmd.elem  = 1'b1;
          state_nxt = ST_ACC;
        end else if (stat.is_end) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = stat.finish ? ST_INS : ST_IDLE;
      end
      ST_INS: begin
        cmd.insert = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.emit_done) begin
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `ASSERT_NEXT(a_load_busy, clk, rst_n, cmd.load, busy, "load did not raise busy")
  `ASSERT_CLK(a_cmd_onehot, clk, rst_n, $onehot0({cmd.load, cmd.elem, cmd.acc, cmd.insert, cmd.emit}), "commands overlap")
  `ASSERT_NEXT(a_ins_idle, clk, rst_n, cmd.insert, state_r == ST_IDLE, "insert not single cycle")
endmodule

// ----- rtl/core/knn_dp.sv -----
`include "assert_macros.svh"
module knn_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  knn_pkg::dp_cmd_t            cmd,
  output knn_pkg::dp_stat_t           stat,
  input  logic [1:0]                  in_kind,
  input  logic signed [15:0]          in_value,
  input  logic [6:0]                  top_count,
  input  logic [10:0]                 vector_length,
  input  logic                        len_wr,
  output logic                        out_valid,
  output logic [19:0]                 out_neighbor_id,
  output logic [43:0]                 out_distance,
  output logic                        out_last
);
  import knn_pkg::*;

  // query store
  logic signed [SAMPLE_BITS-1:0] qmem [MAX_DIM];
  logic signed [SAMPLE_BITS-1:0] q_rd_r;
  logic [1:0]                    kind_r;
  logic signed [SAMPLE_BITS-1:0] val_r;
  logic [DIM_W:0]                eidx_r;
  logic [DIST_W-1:0]             acc_r;
  logic [2*SAMPLE_BITS-1:0]      sq_r;
  logic [BASE_W-1:0]             base_r;
  logic [DIST_W-1:0]             cand_d_r;
  logic [ID_W-1:0]               cand_id_r;

  // sorted list cells
  logic [DIST_W-1:0] ld_r  [MAX_K];
  logic [ID_W-1:0]   lid_r [MAX_K];
  logic [K_W:0]      fill_r;
  logic [K_W:0]      emit_idx_r;
  logic              out_valid_r;
  logic [ID_W-1:0]   out_id_r;
  logic [DIST_W-1:0] out_d_r;
  logic              out_last_r;

  logic [DIM_W:0]  eff_len;
  logic [K_W:0]    eff_top, n_emit;
  logic [DIM_W:0]  eidx_inc;
  logic signed [SAMPLE_BITS:0] diff;
  logic [SAMPLE_BITS:0]        mag;
  logic [DIST_W:0]             sum;
  logic [DIST_W-1:0]           acc_new;
  logic [MAX_K-1:0]            better;   // entry i stays ahead of candidate

  always_comb begin
    if (vector_length == '0) eff_len = (DIM_W+1)'(1);
    else if (vector_length > 11'(MAX_DIM)) eff_len = (DIM_W+1)'(MAX_DIM);
    else eff_len = (DIM_W+1)'(vector_length);
    if (top_count == '0) eff_top = (K_W+1)'(1);
    else if (top_count > 7'(MAX_K)) eff_top = (K_W+1)'(MAX_K);
    else eff_top = (K_W+1)'(top_count);
    n_emit   = (eff_top > fill_r) ? fill_r : eff_top;
    eidx_inc = eidx_r + 1'b1;
    diff     = $signed({val_r[SAMPLE_BITS-1], val_r}) - $signed({q_rd_r[SAMPLE_BITS-1], q_rd_r});
    mag      = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : (SAMPLE_BITS+1)'(diff);
    sum      = {1'b0, acc_r} + (DIST_W+1)'(sq_r);
    acc_new  = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
  end

  assign stat.is_query  = kind_r == KIND_QUERY;
  assign stat.is_base   = kind_r == KIND_BASE;
  assign stat.is_end    = kind_r == KIND_END;
  assign stat.finish    = eidx_inc >= eff_len;
  assign stat.emit_done = emit_idx_r >= n_emit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      val_r  <= in_value;
      q_rd_r <= qmem[eidx_r[DIM_W-1:0]];
    end
    if (cmd.elem && kind_r == KIND_QUERY) qmem[eidx_r[DIM_W-1:0]] <= val_r;
    if (cmd.elem) sq_r <= (2*SAMPLE_BITS)'(mag * mag);
    if (cmd.acc) begin
      cand_d_r  <= acc_new;
      cand_id_r <= base_r[ID_W-1:0];
    end
  end

  // control-ish counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eidx_r <= '0;
      acc_r  <= '0;
      base_r <= '0;
    end else if (len_wr) begin
      eidx_r <= '0;
      acc_r  <= '0;
    end else if (cmd.clear) begin
      eidx_r <= '0;
      acc_r  <= '0;
      base_r <= '0;
    end else if (cmd.elem && kind_r == KIND_QUERY) begin
      acc_r  <= '0;
      eidx_r <= (eidx_inc >= eff_len) ? '0 : eidx_inc;
    end else if (cmd.acc) begin
      if (eidx_inc >= eff_len) begin
        eidx_r <= '0;
        acc_r  <= '0;
      end else begin
        eidx_r <= eidx_inc;
        acc_r  <= acc_new;
      end
    end else if (cmd.insert && base_r < BASE_W'(MAX_BASE)) begin
      base_r <= base_r + 1'b1;
    end
  end

  // each cell compares against the candidate; ties keep older (lower id) first
  always_comb begin
    for (int i = 0; i < MAX_K; i++)
      better[i] = ((K_W+1)'(i) < fill_r) && (ld_r[i] <= cand_d_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && base_r < BASE_W'(MAX_BASE)) begin
      for (int i = 0; i < MAX_K; i++) begin
        if (!better[i]) begin
          if (i == 0 || better[(i == 0) ? 0 : i-1]) begin
            ld_r[i]  <= cand_d_r;
            lid_r[i] <= cand_id_r;
          end else begin
            ld_r[i]  <= ld_r[(i == 0) ? 0 : i-1];
            lid_r[i] <= lid_r[(i == 0) ? 0 : i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.clear) begin
      fill_r <= '0;
    end else if (cmd.insert && base_r < BASE_W'(MAX_BASE) && fill_r < (K_W+1)'(MAX_K)) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cmd.emit) begin
        if (cmd.clear) emit_idx_r <= '0;
        else begin
          emit_idx_r  <= emit_idx_r + 1'b1;
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && !cmd.clear) begin
      out_id_r   <= lid_r[emit_idx_r[K_W-1:0]];
      out_d_r    <= ld_r[emit_idx_r[K_W-1:0]];
      out_last_r <= (emit_idx_r + 1'b1) == n_emit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_neighbor_id = out_id_r;
  assign out_distance    = out_d_r;
  assign out_last        = out_last_r;

  `ASSERT_CLK(a_fill_max, clk, rst_n, fill_r <= (K_W+1)'(MAX_K), "list overfilled")
  `ASSERT_CLK(a_eidx_rng, clk, rst_n, eidx_r < (DIM_W+1)'(MAX_DIM), "element index out of range")
  `ASSERT_NEXT(a_clear_fill, clk, rst_n, cmd.clear && !len_wr, fill_r == '0, "clear left entries")
endmodule

// ----- rtl/core/knn_l2_topk_search.sv -----
// knn_l2_topk_search: exact k-nearest-neighbour search, squared L2 distance.
// Query element: loaded, then written to the query store. Base element: loaded, squared,
//   accumulated; the final one also inserts into the sorted 64-cell list in one step.
// End item: after the element state, the emit state presents the list through
//   registered outputs, one result per cycle; no stall possible at the receiver.
// Start is taken only when not busy; reset (rst_n, synchronous) empties the list.
module knn_l2_topk_search (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_value,
  output logic               out_valid,
  output logic [19:0]        out_neighbor_id,
  output logic [43:0]        out_distance,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import knn_pkg::*;

  logic [6:0]  cfg_top_count_r;
  logic [10:0] cfg_vector_length_r;
  logic        wr_en, len_wr;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  // register write on the APB access phase
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign len_wr = wr_en && (paddr[2] == REG_LEN) && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_top_count_r     <= 7'd64;
      cfg_vector_length_r <= 11'd128;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_TOP) cfg_top_count_r <= pwdata[6:0];
      else                     cfg_vector_length_r <= pwdata[10:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_TOP) prdata = 32'(cfg_top_count_r);
      else                     prdata = 32'(cfg_vector_length_r);
    end
  end

  knn_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  knn_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .top_count       (cfg_top_count_r),
    .vector_length   (cfg_vector_length_r),
    .len_wr          (len_wr),
    .out_valid       (out_valid),
    .out_neighbor_id (out_neighbor_id),
    .out_distance    (out_distance),
    .out_last        (out_last)
  );
endmodule
